// ===== hdl/refcounted_handle_table_defines.svh =====
// Assertion macros used by the handle table datapath (rht_dp).
// Needs signals named clk and arst_n in the module that uses them.
`ifndef REFCOUNTED_HANDLE_TABLE_DEFINES_SVH
`define REFCOUNTED_HANDLE_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rht_pkg.sv =====
// Shared types and constants for the reference-counted handle table.
// Used by rht_ctrl, rht_dp and refcounted_handle_table; depends on nothing.
package rht_pkg;

	localparam int CAPACITY    = 64;
	localparam int REF_WIDTH   = 16;
	localparam int SLOT_W      = $clog2(CAPACITY);
	localparam int LIVE_W      = $clog2(CAPACITY + 1);
	localparam int HANDLE_W    = 32;
	localparam int PAYLOAD_W   = 32;
	localparam int LIMIT_W     = 7;
	localparam int LIVE_OUT_W  = 7;
	localparam int MAX_RESULTS = 64;
	localparam int ADD_LIMIT   = CAPACITY * 3 / 4;

	localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		FUNC_ADD  = 2'd0,
		FUNC_GET  = 2'd1,
		FUNC_REL  = 2'd2,
		FUNC_LIST = 2'd3
	} func_t;

	// What the result staging register takes in this cycle.
	typedef enum logic [2:0] {
		STG_NONE  = 3'd0,
		STG_CLEAR = 3'd1,
		STG_ADD   = 3'd2,
		STG_RMW   = 3'd3,
		STG_LIST  = 3'd4
	} stage_op_t;

	typedef struct packed {
		logic      load_in;
		stage_op_t stage;
		logic      probe;
		logic      rmw;
		logic      list_init;
		logic      scan_adv;
		logic      list_take;
		logic      push;
		logic      push_last;
	} ctl_cmd_t;

	typedef struct packed {
		func_t func;
		logic  add_refused;
		logic  probe_free;
		logic  slot_live;
		logic  idx_last;
		logic  limit_zero;
		logic  limit_hit;
		logic  n_nonzero;
		logic  out_free;
	} dp_stat_t;

endpackage

// ===== hdl/refcounted_handle_table.sv =====
// Top level of the reference-counted handle table.
// Depends on rht_pkg, rht_ctrl (sequencer) and rht_dp (memories and counters).
//
//  Channel  Handshake            Item contents
//  -------  -------------------  -----------------------------------------------------
//  in       in_valid / in_ready  func, handle, payload, list_limit
//  out      out_valid/ out_ready result_handle, result_payload, ok, live_total, last
//
// Get and release go through capture, memory read, read-modify-write of the count and
// result. Add goes through capture and decode, then probes the occupancy bits, each
// probe trying the next handle number, until a free slot is found; a refused add goes
// straight to its result. List reads the slots in turn, with a check step for each
// live slot, taken after the handle memory read; it stops early when the limit is reached.
// Reset clears the occupancy bits, the handle counter and the live count at once, so
// no clearing pass runs. The next item is accepted as soon as the previous one has
// placed its final result in the output register; a stalled output holds the
// sequencer before it pushes another result.
module refcounted_handle_table
	import rht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [HANDLE_W-1:0]   handle,
	input  logic [PAYLOAD_W-1:0]  payload,
	input  logic [LIMIT_W-1:0]    list_limit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [HANDLE_W-1:0]   result_handle,
	output logic [PAYLOAD_W-1:0]  result_payload,
	output logic                  ok,
	output logic [LIVE_OUT_W-1:0] live_total,
	output logic                  last
);

	// Commands from the sequencer and status back from the datapath.
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// The sequencer decides what happens each cycle; it holds no payload.
	rht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the slot memories, the occupancy bits, the scan
	// counters and the output register that decouples the result channel.
	rht_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.func           (func),
		.handle         (handle),
		.payload        (payload),
		.list_limit     (list_limit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_handle  (result_handle),
		.result_payload (result_payload),
		.ok             (ok),
		.live_total     (live_total),
		.last           (last)
	);

endmodule

// ===== hdl/rht_ctrl.sv =====
// Sequencing state machine of the handle table.
// Depends on rht_pkg; drives rht_dp through ctl_cmd_t and reads dp_stat_t.
module rht_ctrl
	import rht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DECODE   = 7'b0000010,
		S_PROBE    = 7'b0000100,
		S_RMW      = 7'b0001000,
		S_SCAN_RD  = 7'b0010000,
		S_SCAN_CHK = 7'b0100000,
		S_RESP     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.func)
					FUNC_ADD: begin
						if (stat.add_refused) begin
							cmd.stage = STG_CLEAR;
							state_d   = S_RESP;
						end else begin
							state_d = S_PROBE;
						end
					end
					FUNC_GET, FUNC_REL: begin
						state_d = S_RMW;
					end
					FUNC_LIST: begin
						cmd.list_init = 1'b1;
						cmd.stage     = STG_CLEAR;
						state_d       = stat.limit_zero ? S_RESP : S_SCAN_RD;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				if (stat.probe_free) begin
					cmd.stage = STG_ADD;
					state_d   = S_RESP;
				end
			end
			S_RMW: begin
				cmd.rmw   = 1'b1;
				cmd.stage = STG_RMW;
				state_d   = S_RESP;
			end
			S_SCAN_RD: begin
				if (stat.slot_live) begin
					state_d = S_SCAN_CHK;
				end else if (stat.idx_last) begin
					state_d = S_RESP;
				end else begin
					cmd.scan_adv = 1'b1;
				end
			end
			S_SCAN_CHK: begin
				if (!stat.n_nonzero || stat.out_free) begin
					cmd.push      = stat.n_nonzero;
					cmd.stage     = STG_LIST;
					cmd.list_take = 1'b1;
					if (stat.limit_hit || stat.idx_last) begin
						state_d = S_RESP;
					end else begin
						cmd.scan_adv = 1'b1;
						state_d      = S_SCAN_RD;
					end
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/rht_dp.sv =====
// Datapath of the handle table: slot memories, valid bits, counters, output register.
// Depends on rht_pkg and refcounted_handle_table_defines.svh; commanded by rht_ctrl.
`include "refcounted_handle_table_defines.svh"

module rht_dp
	import rht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat,
	input  logic [1:0]            func,
	input  logic [HANDLE_W-1:0]   handle,
	input  logic [PAYLOAD_W-1:0]  payload,
	input  logic [LIMIT_W-1:0]    list_limit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [HANDLE_W-1:0]   result_handle,
	output logic [PAYLOAD_W-1:0]  result_payload,
	output logic                  ok,
	output logic [LIVE_OUT_W-1:0] live_total,
	output logic                  last
);

	logic [HANDLE_W-1:0]  handle_mem  [CAPACITY];
	logic [PAYLOAD_W-1:0] payload_mem [CAPACITY];
	logic [REF_WIDTH-1:0] refs_mem    [CAPACITY];

	logic [HANDLE_W-1:0]  rd_handle_s1;
	logic [PAYLOAD_W-1:0] rd_payload_s1;
	logic [REF_WIDTH-1:0] rd_refs_s1;

	logic [CAPACITY-1:0]  valid_q;
	logic [HANDLE_W-1:0]  last_handle_q;
	logic [LIVE_W-1:0]    live_q;

	func_t                func_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [LIMIT_W-1:0]   lim_q;
	logic [LIMIT_W-1:0]   n_q;
	logic [SLOT_W-1:0]    idx_q;

	logic [HANDLE_W-1:0]  res_handle_q;
	logic [PAYLOAD_W-1:0] res_payload_q;
	logic                 res_ok_q;

	logic                 out_valid_q;
	logic [HANDLE_W-1:0]  out_handle_q;
	logic [PAYLOAD_W-1:0] out_payload_q;
	logic                 out_ok_q;
	logic [LIVE_W-1:0]    out_live_q;
	logic                 out_last_q;

	logic [HANDLE_W-1:0]  h_inc;
	logic [HANDLE_W-1:0]  h_next;
	logic [SLOT_W-1:0]    slot_h;
	logic [SLOT_W-1:0]    slot_r;
	logic [SLOT_W-1:0]    rd_addr;
	logic                 probe_free;
	logic                 rmw_hit;
	logic                 rmw_free;
	logic [REF_WIDTH-1:0] refs_new;
	logic                 we_all;
	logic                 we_refs;
	logic [SLOT_W-1:0]    wr_addr;
	logic [REF_WIDTH-1:0] wr_refs;
	logic                 out_free;

	// Next handle number: one up, wrapping at 32 bits and never zero.
	assign h_inc  = last_handle_q + HANDLE_W'(1);
	assign h_next = (h_inc == '0) ? HANDLE_W'(1) : h_inc;
	assign slot_h = h_next[SLOT_W-1:0];
	assign slot_r = handle_q[SLOT_W-1:0];
	assign probe_free = !valid_q[slot_h];

	assign rd_addr = (func_q == FUNC_LIST) ? idx_q : slot_r;

	assign rmw_hit  = valid_q[slot_r] && (rd_handle_s1 == handle_q) && (handle_q != '0);
	assign rmw_free = (func_q == FUNC_REL) && (rd_refs_s1 <= REF_WIDTH'(1));

	always_comb begin
		if (func_q == FUNC_GET) begin
			refs_new = (rd_refs_s1 == REF_MAX) ? rd_refs_s1 : rd_refs_s1 + REF_WIDTH'(1);
		end else if (rd_refs_s1 <= REF_WIDTH'(1)) begin
			refs_new = '0;
		end else begin
			refs_new = rd_refs_s1 - REF_WIDTH'(1);
		end
	end

	assign we_all  = cmd.probe && probe_free;
	assign we_refs = we_all || (cmd.rmw && rmw_hit);
	assign wr_addr = cmd.probe ? slot_h : slot_r;
	assign wr_refs = cmd.probe ? REF_WIDTH'(1) : refs_new;

	assign out_free = !out_valid_q || out_ready;

	// Slot memories: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we_all) begin
			handle_mem[wr_addr]  <= h_next;
			payload_mem[wr_addr] <= payload_q;
		end
		if (we_refs) begin
			refs_mem[wr_addr] <= wr_refs;
		end
		rd_handle_s1  <= handle_mem[rd_addr];
		rd_payload_s1 <= payload_mem[rd_addr];
		rd_refs_s1    <= refs_mem[rd_addr];
	end

	// Occupancy, handle counter and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			last_handle_q <= '0;
			live_q        <= '0;
			func_q        <= FUNC_ADD;
			idx_q         <= '0;
			n_q           <= '0;
			lim_q         <= '0;
		end else begin
			if (cmd.load_in) begin
				func_q <= func_t'(func);
			end
			if (cmd.probe) begin
				last_handle_q <= h_next;
				if (probe_free) begin
					valid_q[slot_h] <= 1'b1;
					live_q          <= live_q + LIVE_W'(1);
				end
			end
			if (cmd.rmw && rmw_hit && rmw_free) begin
				valid_q[slot_r] <= 1'b0;
				live_q          <= live_q - LIVE_W'(1);
			end
			if (cmd.list_init) begin
				idx_q <= '0;
				n_q   <= '0;
				lim_q <= (limit_q > LIMIT_W'(MAX_RESULTS)) ? LIMIT_W'(MAX_RESULTS) : limit_q;
			end
			if (cmd.scan_adv) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			if (cmd.list_take) begin
				n_q <= n_q + LIMIT_W'(1);
			end
		end
	end

	// Input capture and result staging.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			handle_q  <= handle;
			payload_q <= payload;
			limit_q   <= list_limit;
		end
		case (cmd.stage)
			STG_CLEAR: begin
				res_handle_q  <= '0;
				res_payload_q <= '0;
				res_ok_q      <= 1'b0;
			end
			STG_ADD: begin
				res_handle_q  <= h_next;
				res_payload_q <= '0;
				res_ok_q      <= 1'b1;
			end
			STG_RMW: begin
				res_handle_q  <= '0;
				res_ok_q      <= rmw_hit;
				res_payload_q <= (rmw_hit && (func_q == FUNC_GET || rmw_free)) ?
					rd_payload_s1 : '0;
			end
			STG_LIST: begin
				res_handle_q  <= rd_handle_s1;
				res_payload_q <= '0;
				res_ok_q      <= 1'b1;
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_handle_q  <= res_handle_q;
			out_payload_q <= res_payload_q;
			out_ok_q      <= res_ok_q;
			out_live_q    <= live_q;
			out_last_q    <= cmd.push_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_handle  = out_handle_q;
	assign result_payload = out_payload_q;
	assign ok             = out_ok_q;
	assign live_total     = LIVE_OUT_W'(out_live_q);
	assign last           = out_last_q;

	assign stat.func        = func_q;
	assign stat.add_refused = (payload_q == '0) || (live_q >= LIVE_W'(ADD_LIMIT));
	assign stat.probe_free  = probe_free;
	assign stat.slot_live   = valid_q[idx_q];
	assign stat.idx_last    = (idx_q == SLOT_W'(CAPACITY - 1));
	assign stat.limit_zero  = (limit_q == '0);
	assign stat.limit_hit   = ((n_q + LIMIT_W'(1)) == lim_q);
	assign stat.n_nonzero   = (n_q != '0);
	assign stat.out_free    = out_free;

	`RHT_ASSERT_NOW(a_live_matches_valid, 1'b1, $countones(valid_q) == live_q, "live count differs from occupied slots")
	`RHT_ASSERT_NOW(a_push_only_when_free, cmd.push, out_free, "result pushed over an untaken result")
	`RHT_ASSERT_NEXT(a_probe_fills_slot, cmd.probe && probe_free, valid_q[$past(slot_h)], "probed slot not marked live")
	`RHT_ASSERT_NEXT(a_free_drops_live, cmd.rmw && rmw_hit && rmw_free, live_q == $past(live_q) - LIVE_W'(1), "freeing release did not lower live count")

endmodule
